FILE: rtl/fud_pkg.sv
// Package for the form-urlencoded pair decoder.
// Holds byte codes, phase/role/error codes and the shared result types.
// No dependencies.
package fud_pkg;

  localparam logic [7:0] HEX_CASE_MASK = 8'hdf;
  localparam logic [7:0] ESCAPE_BYTE   = 8'h25;
  localparam logic [7:0] PLUS_BYTE     = 8'h2b;
  localparam logic [7:0] SPACE_BYTE    = 8'h20;
  localparam logic [7:0] PAIR_SEP      = 8'h26;
  localparam logic [7:0] NAME_SEP      = 8'h3d;
  localparam logic [7:0] DIGIT_ZERO    = 8'h30;
  localparam logic [7:0] LETTER_A      = 8'h41;
  localparam logic [7:0] HEX_TEN       = 8'h0a;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_NAME  = 2'd1;
  localparam logic [1:0] PHASE_VALUE = 2'd2;
  localparam logic [1:0] PHASE_DROP  = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [1:0] ROLE_NAME     = 2'd0;
  localparam logic [1:0] ROLE_VALUE    = 2'd1;
  localparam logic [1:0] ROLE_PAIR_END = 2'd2;
  localparam logic [1:0] ROLE_REQ_END  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_VALUE  = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0] phase;
    logic       name_seen;
    logic       value_seen;
    logic [1:0] esc;
    logic [3:0] high_digit;
    logic [1:0] err;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] role;
    logic [1:0] status;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } step_out_t;

  localparam dec_state_t STATE_RESET = '{
    phase: PHASE_IDLE, name_seen: 1'b0, value_seen: 1'b0,
    esc: ESC_NONE, high_digit: 4'd0, err: ERR_NONE
  };

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= LETTER_A) begin
      v = (c & HEX_CASE_MASK) - LETTER_A + HEX_TEN;
    end else begin
      v = c - DIGIT_ZERO;
    end
    return v;
  endfunction

  function automatic logic pair_end_ok(input dec_state_t s);
    return (s.phase != PHASE_IDLE) && (s.phase != PHASE_NAME) && s.value_seen &&
           (s.esc == ESC_NONE);
  endfunction

  function automatic dec_state_t close_state(input dec_state_t s);
    dec_state_t r;
    r = s;
    if (s.phase != PHASE_IDLE) begin
      if (s.phase == PHASE_NAME || !s.value_seen) begin
        r.err = ERR_NO_VALUE;
      end else if (s.esc != ESC_NONE) begin
        r.err = ERR_TRUNCATED;
      end
      r.phase      = PHASE_IDLE;
      r.name_seen  = 1'b0;
      r.value_seen = 1'b0;
      r.esc        = ESC_NONE;
      r.high_digit = 4'd0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/fud_core.sv
// Per-byte decode step: tokenizer state registers and the result list
// produced by one accepted byte. Depends on fud_pkg.
module fud_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_request,
  output fud_pkg::step_out_t    step
);

  fud_pkg::dec_state_t st;
  fud_pkg::dec_state_t st_next;
  fud_pkg::dec_state_t s;
  fud_pkg::result_t    slot [fud_pkg::MAX_RESULTS];
  logic [1:0]          n;
  logic [7:0]          c;
  logic [7:0]          dig;

  always_comb begin
    s   = st;
    n   = 2'd0;
    for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
      slot[i] = '0;
    end
    c   = (in_byte == fud_pkg::PLUS_BYTE) ? fud_pkg::SPACE_BYTE : in_byte;
    dig = fud_pkg::digit_value(c);

    if (s.err == fud_pkg::ERR_NONE) begin
      if (in_byte == fud_pkg::PAIR_SEP) begin
        if (fud_pkg::pair_end_ok(s)) begin
          slot[n].role = fud_pkg::ROLE_PAIR_END;
          n = n + 2'd1;
        end
        s = fud_pkg::close_state(s);
      end else if (in_byte == fud_pkg::NAME_SEP) begin
        if (s.phase == fud_pkg::PHASE_IDLE) begin
          s.phase = fud_pkg::PHASE_NAME;
        end else if (s.phase == fud_pkg::PHASE_NAME) begin
          if (s.name_seen) begin
            s.phase = fud_pkg::PHASE_VALUE;
          end
        end else if (s.phase == fud_pkg::PHASE_VALUE && s.value_seen) begin
          if (s.esc != fud_pkg::ESC_NONE) begin
            s            = fud_pkg::STATE_RESET;
            s.err        = fud_pkg::ERR_TRUNCATED;
          end else begin
            s.phase = fud_pkg::PHASE_DROP;
          end
        end
      end else if (s.phase == fud_pkg::PHASE_IDLE || s.phase == fud_pkg::PHASE_NAME) begin
        s.phase        = fud_pkg::PHASE_NAME;
        s.name_seen    = 1'b1;
        slot[n].out_byte = in_byte;
        slot[n].role     = fud_pkg::ROLE_NAME;
        n = n + 2'd1;
      end else if (s.phase == fud_pkg::PHASE_VALUE) begin
        s.value_seen = 1'b1;
        if (s.esc == fud_pkg::ESC_NONE) begin
          if (in_byte == fud_pkg::ESCAPE_BYTE) begin
            s.esc = fud_pkg::ESC_HIGH;
          end else begin
            slot[n].out_byte = c;
            slot[n].role     = fud_pkg::ROLE_VALUE;
            n = n + 2'd1;
          end
        end else if (s.esc == fud_pkg::ESC_HIGH) begin
          s.high_digit = dig[3:0];
          s.esc        = fud_pkg::ESC_LOW;
        end else begin
          slot[n].out_byte = {s.high_digit, 4'd0} + dig;
          slot[n].role     = fud_pkg::ROLE_VALUE;
          n = n + 2'd1;
          s.esc = fud_pkg::ESC_NONE;
        end
      end
    end

    if (end_of_request) begin
      if (s.err == fud_pkg::ERR_NONE) begin
        if (fud_pkg::pair_end_ok(s)) begin
          slot[n].role = fud_pkg::ROLE_PAIR_END;
          n = n + 2'd1;
        end
        s = fud_pkg::close_state(s);
      end
      slot[n].role        = fud_pkg::ROLE_REQ_END;
      slot[n].status      = s.err;
      slot[n].last_result = 1'b1;
      n = n + 2'd1;
      s = fud_pkg::STATE_RESET;
    end

    st_next    = s;
    step.count = n;
    for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
      step.res[i] = slot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fud_pkg::STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

FILE: rtl/fud_outq.sv
// Result register for one byte's worth of results, drained one per cycle while m_tready is high.
// Depends on fud_pkg.
module fud_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fud_pkg::step_out_t  step,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output fud_pkg::result_t    head
);

  fud_pkg::result_t q [fud_pkg::MAX_RESULTS];
  logic [1:0]       cnt;
  logic [1:0]       idx;
  logic             pop;
  logic             last_pop;

  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign last_pop = pop && (idx == cnt - 2'd1);
  assign free     = (cnt == 2'd0) || last_pop;
  assign head     = q[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= step.count;
      idx <= 2'd0;
    end else if (last_pop) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
        q[i] <= step.res[i];
      end
    end
  end

endmodule

FILE: rtl/form_urlencoded_pair_decoder_top.sv
// Top level of the form-urlencoded pair decoder: stream ports, decode step
// and result register. Depends on fud_pkg, fud_core, fud_outq.
//
//  channel | dir | tdata        | tuser                    | tlast
//  s_*     | in  | in_byte[7:0] | -                        | end_of_request
//  m_*     | out | out_byte     | role[1:0], status[3:2]   | last_result
//
// Each byte is decoded into 0 to 3 results held in the result register;
// results leave one per cycle while m_tready is high. A byte yielding at
// most one result sustains one byte per cycle while m_tready is high;
// the result register drain sets the rate otherwise. Reset returns the
// tokenizer to between pairs with no error and empties the result register.
// s_tready is high only when the register is empty or its last result pops.
module form_urlencoded_pair_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic [3:0] m_tuser,   // role[1:0], status[3:2]
  output logic       m_tlast
);

  logic               accept;
  logic               free;
  fud_pkg::step_out_t step;
  fud_pkg::result_t   head;

  assign s_tready = free;
  assign accept   = s_tvalid && free;

  fud_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (s_tdata),
    .end_of_request (s_tlast),
    .step           (step)
  );

  fud_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .step     (step),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = {head.status, head.role};
  assign m_tlast = head.last_result;

endmodule
